// File: hw/rtl/csum_pkg.sv
// shared types, constants and the ones' complement adder for the checksum block
// no dependencies
package csum_pkg;

    localparam int DATA_W     = 8;
    localparam int SUM_W      = 16;
    localparam int COUNT_W    = 17;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int PROTO_W    = 8;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PSEUDO_MODE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SRC_ADDR    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DST_ADDR    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PROTO       = 2'd3;

    typedef struct packed {
        logic                  pseudo_mode;
        logic [CFG_DATA_W-1:0] source_address;
        logic [CFG_DATA_W-1:0] dest_address;
        logic [PROTO_W-1:0]    proto_number;
    } cfg_t;

    // message summary handed from the accumulator to the finishing stage
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
    } msg_end_t;

    function automatic logic [SUM_W-1:0] oc_add(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        logic [SUM_W:0] f;
        s = {1'b0, a} + {1'b0, b};
        f = {1'b0, s[SUM_W-1:0]} + {{SUM_W{1'b0}}, s[SUM_W]};
        return f[SUM_W-1:0];
    endfunction

endpackage

// File: hw/rtl/csum_accum.sv
// byte input register and running ones' complement accumulator
// depends on csum_pkg
module csum_accum (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [csum_pkg::DATA_W-1:0] in_byte,
    input  logic                      in_last,
    output logic                      end_valid,
    input  logic                      end_ready,
    output csum_pkg::msg_end_t        end_word
);
    import csum_pkg::*;

    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    logic                byte_valid_reg;
    logic [DATA_W-1:0]   byte_data_reg;
    logic                byte_last_reg;

    logic [SUM_W-1:0]    running_sum_reg;
    logic [SUM_W-1:0]    running_sum_next;
    logic [DATA_W-1:0]   pending_high_reg;
    logic [DATA_W-1:0]   pending_high_next;
    logic                odd_pending_reg;
    logic                odd_pending_next;
    logic [COUNT_W-1:0]  byte_count_reg;
    logic [COUNT_W-1:0]  byte_count_next;

    logic                end_valid_reg;
    msg_end_t            end_word_reg;

    logic                adv;
    logic                end_free;
    logic [SUM_W-1:0]    word;
    logic [SUM_W-1:0]    word_sum;
    logic [COUNT_W-1:0]  count_inc;

    assign end_free = !end_valid_reg || end_ready;
    assign adv      = byte_valid_reg && (!byte_last_reg || end_free);
    assign in_ready = !byte_valid_reg || adv;

    // a lone final byte is padded low
    assign word      = odd_pending_reg ? {pending_high_reg, byte_data_reg}
                                       : {byte_data_reg, {DATA_W{1'b0}}};
    assign word_sum  = oc_add(running_sum_reg, word);
    // saturates at 65536
    assign count_inc = byte_count_reg[COUNT_W-1] ? byte_count_reg
                                                 : byte_count_reg + COUNT_ONE;

    always_comb begin
        running_sum_next  = running_sum_reg;
        pending_high_next = pending_high_reg;
        odd_pending_next  = odd_pending_reg;
        byte_count_next   = byte_count_reg;
        if (adv) begin
            if (byte_last_reg) begin
                running_sum_next  = '0;
                pending_high_next = '0;
                odd_pending_next  = 1'b0;
                byte_count_next   = '0;
            end else begin
                byte_count_next = count_inc;
                if (odd_pending_reg) begin
                    running_sum_next  = word_sum;
                    pending_high_next = '0;
                    odd_pending_next  = 1'b0;
                end else begin
                    pending_high_next = byte_data_reg;
                    odd_pending_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_valid_reg   <= 1'b0;
            running_sum_reg  <= '0;
            pending_high_reg <= '0;
            odd_pending_reg  <= 1'b0;
            byte_count_reg   <= '0;
            end_valid_reg    <= 1'b0;
        end else begin
            if (in_ready) begin
                byte_valid_reg <= in_valid;
            end
            running_sum_reg  <= running_sum_next;
            pending_high_reg <= pending_high_next;
            odd_pending_reg  <= odd_pending_next;
            byte_count_reg   <= byte_count_next;
            if (end_free) begin
                end_valid_reg <= adv && byte_last_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            byte_data_reg <= in_byte;
            byte_last_reg <= in_last;
        end
        if (adv && byte_last_reg) begin
            end_word_reg.sum   <= word_sum;
            end_word_reg.count <= count_inc;
        end
    end

    assign end_valid = end_valid_reg;
    assign end_word  = end_word_reg;

endmodule

// File: hw/rtl/csum_final.sv
// pseudo header addition, length check, complement and result register
// depends on csum_pkg
module csum_final (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  csum_pkg::cfg_t                cfg,
    input  logic                          end_valid,
    output logic                          end_ready,
    input  csum_pkg::msg_end_t            end_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [csum_pkg::SUM_W-1:0]    out_checksum,
    output logic                          out_length_error
);
    import csum_pkg::*;

    localparam int WIDE_W = SUM_W + 3;

    logic               out_valid_reg;
    logic [SUM_W-1:0]   checksum_reg;
    logic [SUM_W-1:0]   checksum_next;
    logic               length_error_reg;
    logic               length_error_next;

    logic [WIDE_W-1:0]  wide_sum;
    logic [SUM_W:0]     fold1;
    logic [SUM_W:0]     fold2;

    // seven 16-bit terms, then two end-around folds
    always_comb begin
        wide_sum = WIDE_W'(end_word.sum)
                 + WIDE_W'(cfg.source_address[CFG_DATA_W-1:SUM_W])
                 + WIDE_W'(cfg.source_address[SUM_W-1:0])
                 + WIDE_W'(cfg.dest_address[CFG_DATA_W-1:SUM_W])
                 + WIDE_W'(cfg.dest_address[SUM_W-1:0])
                 + WIDE_W'(cfg.proto_number)
                 + WIDE_W'(end_word.count[SUM_W-1:0]);
        fold1 = {1'b0, wide_sum[SUM_W-1:0]} + (SUM_W+1)'(wide_sum[WIDE_W-1:SUM_W]);
        fold2 = {1'b0, fold1[SUM_W-1:0]} + (SUM_W+1)'(fold1[SUM_W]);
    end

    always_comb begin
        length_error_next = 1'b0;
        if (cfg.pseudo_mode) begin
            if (end_word.count[COUNT_W-1]) begin
                checksum_next     = '0;
                length_error_next = 1'b1;
            end else begin
                checksum_next = ~fold2[SUM_W-1:0];
            end
        end else begin
            checksum_next = ~end_word.sum;
        end
    end

    assign end_ready = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (end_ready) begin
            out_valid_reg <= end_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (end_ready && end_valid) begin
            checksum_reg     <= checksum_next;
            length_error_reg <= length_error_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_checksum     = checksum_reg;
    assign out_length_error = length_error_reg;

endmodule

// File: hw/rtl/internet_checksum_pseudo_header.sv
// streaming internet checksum with optional ipv4 pseudo header, top level
// depends on csum_pkg, csum_accum, csum_final
//
//  channel | direction | payload
//  s_      | in        | tdata[7:0] byte of message, tlast marks final byte
//  m_      | out       | tdata[15:0] checksum, tuser[0] length error
//  cfg_    | in        | cfg_index selects register, cfg_wdata value, cfg_we strobe
//
// one byte per cycle unless stalled; the byte adder in csum_accum is the per-byte loop
// a result passes the input, message end and result registers on its way to m_
// aresetn clears the stream state and all configuration registers
// a held result stalls s_ only once a last byte waits behind full end and output regs
module internet_checksum_pseudo_header (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // [15:0] checksum
    output logic [0:0]                        m_tuser,   // [0] length_error
    input  logic                              cfg_we,
    input  logic [csum_pkg::CFG_ADDR_W-1:0]   cfg_index,
    input  logic [csum_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import csum_pkg::*;

    cfg_t     cfg_reg;
    logic     end_valid;
    logic     end_ready;
    msg_end_t end_word;
    logic     length_error;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_PSEUDO_MODE: cfg_reg.pseudo_mode    <= cfg_wdata[0];
                REG_SRC_ADDR:    cfg_reg.source_address <= cfg_wdata;
                REG_DST_ADDR:    cfg_reg.dest_address   <= cfg_wdata;
                REG_PROTO:       cfg_reg.proto_number   <= cfg_wdata[PROTO_W-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    csum_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .end_valid (end_valid),
        .end_ready (end_ready),
        .end_word  (end_word)
    );

    csum_final u_final (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .end_valid        (end_valid),
        .end_ready        (end_ready),
        .end_word         (end_word),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_checksum     (m_tdata),
        .out_length_error (length_error)
    );

    assign m_tuser = length_error;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for internet_checksum_pseudo_header: byte stream in, checksum out
// depends on csum_pkg and the internet_checksum_pseudo_header rtl
module tb_top;
    import csum_pkg::*;

    localparam int GAP_MAX     = 12;
    localparam int HOLD_LEN    = 400;
    localparam int HOLD_AT     = 40;
    localparam int DRAIN_WAIT  = 8;
    localparam int STALL_LIMIT = 3000;
    localparam int RAND_BYTES  = 1450;
    localparam int PHASES      = 8;
    localparam int DIR_N       = 21;

    typedef struct packed {
        logic [15:0] csum;
        logic        len_err;
    } csum_word_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        typed;
        logic [15:0] csum;
        logic        len_err;
    } stim_row_t;

    // reset configuration, plain mode; typed rows carry the checksum that is read off directly
    localparam stim_row_t DIR_ROWS [DIR_N] = '{
        '{8'h00, 1'b1, 1'b1, 16'hffff, 1'b0},   // single zero byte
        '{8'hff, 1'b1, 1'b1, 16'h00ff, 1'b0},   // odd byte padded low
        '{8'hff, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'hff, 1'b1, 1'b1, 16'h0000, 1'b0},   // all ones word
        '{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h00, 1'b1, 1'b1, 16'hffff, 1'b0},
        '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},   // end-around carry
        '{8'h00, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h00, 1'b1, 1'b0, 16'h0000, 1'b0},
        '{8'hff, 1'b0, 1'b0, 16'h0000, 1'b0},   // carry plus odd tail
        '{8'hff, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'hff, 1'b1, 1'b0, 16'h0000, 1'b0},
        '{8'h12, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h34, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h56, 1'b1, 1'b0, 16'h0000, 1'b0},
        '{8'haa, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h55, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h5a, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'ha5, 1'b0, 1'b0, 16'h0000, 1'b0},
        '{8'h01, 1'b1, 1'b0, 16'h0000, 1'b0}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // typed expectation travelling alongside the word being offered
    logic                  row_typed = 1'b0;
    logic [15:0]           row_csum  = '0;
    logic                  row_err   = 1'b0;

    // predictor copy of configuration and stream state
    logic                  mode_pseudo = 1'b0;
    logic [31:0]           addr_src    = '0;
    logic [31:0]           addr_dst    = '0;
    logic [7:0]            proto_val   = '0;
    logic [15:0]           acc_sum     = '0;
    logic [7:0]            hi_byte     = '0;
    logic                  hi_valid    = 1'b0;
    logic [16:0]           msg_len     = '0;

    csum_word_t            checksums_due [$];

    int  err_count    = 0;
    int  bytes_in     = 0;
    int  results_seen = 0;
    int  len_errs     = 0;
    int  reg_writes   = 0;
    int  quiet_cycles = 0;
    int  send_streak  = 0;

    internet_checksum_pseudo_header dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [7:0] data_byte
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [15:0] checksum
        .m_tuser   (m_tuser),     // [0] length_error
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // zero-wait stretches now and then, otherwise a random wait
    function automatic int draw_wait(inout int streak);
        if (streak > 0) begin
            streak--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            streak = $urandom_range(8, 30);
            return 0;
        end
        return $urandom_range(0, GAP_MAX);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic absorb_byte(input logic [7:0] b, input logic last, input logic typed,
                               input logic [15:0] csum, input logic len_err);
        logic [15:0] s;
        csum_word_t  w;
        if (hi_valid) begin
            acc_sum  = ones_add(acc_sum, {hi_byte, b});
            hi_valid = 1'b0;
            hi_byte  = 8'h00;
        end else begin
            hi_byte  = b;
            hi_valid = 1'b1;
        end
        if (msg_len < 17'd65536)
            msg_len++;
        if (last) begin
            s = hi_valid ? ones_add(acc_sum, {hi_byte, 8'h00}) : acc_sum;
            if (mode_pseudo && msg_len > 17'd65535) begin
                w.csum    = 16'h0000;
                w.len_err = 1'b1;
            end else begin
                if (mode_pseudo) begin
                    s = ones_add(s, addr_src[31:16]);
                    s = ones_add(s, addr_src[15:0]);
                    s = ones_add(s, addr_dst[31:16]);
                    s = ones_add(s, addr_dst[15:0]);
                    s = ones_add(s, {8'h00, proto_val});
                    s = ones_add(s, msg_len[15:0]);
                end
                w.csum    = ~s;
                w.len_err = 1'b0;
            end
            if (typed) begin
                w.csum    = csum;
                w.len_err = len_err;
            end
            checksums_due.push_back(w);
            acc_sum  = '0;
            hi_byte  = '0;
            hi_valid = 1'b0;
            msg_len  = '0;
        end
    endtask

    always @(posedge aclk) begin : monitor
        csum_word_t want;
        if (aresetn) begin
            if (cfg_we) begin
                reg_writes++;
                case (cfg_index)
                    REG_PSEUDO_MODE: mode_pseudo = cfg_wdata[0];
                    REG_SRC_ADDR:    addr_src    = cfg_wdata;
                    REG_DST_ADDR:    addr_dst    = cfg_wdata;
                    REG_PROTO:       proto_val   = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                bytes_in++;
                absorb_byte(s_tdata, s_tlast, row_typed, row_csum, row_err);
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (m_tuser[0])
                    len_errs++;
                if (checksums_due.size() == 0) begin
                    if (err_count < 10)
                        $display("result %0d: unexpected checksum %h length_error %b",
                                 results_seen, m_tdata, m_tuser[0]);
                    err_count++;
                end else begin
                    want = checksums_due.pop_front();
                    if (m_tdata !== want.csum || m_tuser[0] !== want.len_err) begin
                        if (err_count < 10)
                            $display("result %0d: checksum exp %h got %h, length_error exp %b got %b",
                                     results_seen, want.csum, m_tdata, want.len_err, m_tuser[0]);
                        err_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, checksums_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side, with one long hold-off so the block backs up into its input
    initial begin : receiver
        int gap;
        int streak;
        int taken;
        streak = 0;
        taken  = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = (taken == HOLD_AT) ? HOLD_LEN : draw_wait(streak);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            taken++;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                             input logic [15:0] csum, input logic len_err);
        int gap;
        gap = draw_wait(send_streak);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= b;
        s_tlast   <= last;
        row_typed <= typed;
        row_csum  <= csum;
        row_err   <= len_err;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // random content; a typed error result only for the oversized pseudo header messages
    task automatic send_message(input int len, input logic oversize);
        for (int i = 0; i < len - 1; i++)
            send_byte(pick_byte(), 1'b0, 1'b0, 16'h0000, 1'b0);
        send_byte(pick_byte(), 1'b1, oversize, 16'h0000, oversize);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(negedge aclk);
        while (checksums_due.size() != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic configure(input logic [31:0] pm, input logic [31:0] src,
                             input logic [31:0] dst, input logic [31:0] proto);
        drain_results();
        write_reg(REG_PSEUDO_MODE, pm);
        write_reg(REG_SRC_ADDR, src);
        write_reg(REG_DST_ADDR, dst);
        write_reg(REG_PROTO, proto);
        cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        int len;
        int sent;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_N; i++)
            send_byte(DIR_ROWS[i].data, DIR_ROWS[i].last, DIR_ROWS[i].typed,
                      DIR_ROWS[i].csum, DIR_ROWS[i].len_err);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: configure(32'h1, 32'hffff_ffff, 32'hffff_ffff, 32'hff);
                1: configure(32'h1, 32'h0, 32'h0, 32'h0);
                2: configure(32'h0, $urandom, $urandom, $urandom);
                default: configure($urandom, $urandom, $urandom, $urandom);
            endcase
            sent = 0;
            while (sent < RAND_BYTES / PHASES) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64)
                                                  : $urandom_range(1, 12);
                send_message(len, 1'b0);
                sent += len;
            end
        end
        drain_results();

        if (checksums_due.size() != 0) begin
            $display("%0d expected checksums never arrived", checksums_due.size());
            err_count++;
        end
        $display("run covered %0d bytes, %0d checksums (%0d length errors), %0d register writes",
                 bytes_in, results_seen, len_errs, reg_writes);
        $display("plain and pseudo header modes, extreme addresses, %0d-cycle output hold-off",
                 HOLD_LEN);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
